[sv/dsa_pkg.sv]
// Shared types and constants of the descriptor slot allocator.
package dsa_pkg;

  localparam int SLOT_COUNT = 512;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 16;
  localparam int PROD_W     = IDX_W + SIZE_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd32;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_RELEASE   = 2'd1,
    OP_CPU_QUERY = 2'd2,
    OP_GPU_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPU_BASE  = 2'd0,
    REG_GPU_BASE  = 2'd1,
    REG_DESC_SIZE = 2'd2
  } reg_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;  // take the input word, launch memory reads
    logic commit;   // update state, load the result register
  } cmd_t;

endpackage

[sv/descriptor_slot_allocator.sv]
// Sequence: the input word is captured on accept, then committed into the result register once it has room.
// A new word is not taken until the last one commits, because of the read-modify-write of the
// free stack and in-use map memories between capture and commit.
// The result register frees the input side while a result waits downstream.
// Reset: counters and configuration clear (descriptor_size = 32); memories
// need no clearing pass, in-use entries at or above next_fresh read as clear.
module descriptor_slot_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [dsa_pkg::IDX_W-1:0]         index_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [dsa_pkg::IDX_W-1:0]         slot_o,
  output logic [dsa_pkg::ADDR_W-1:0]        handle_o,
  output logic [dsa_pkg::CNT_W-1:0]         live_slots_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsa_pkg::ADDR_W-1:0]        cfg_data_i
);

  dsa_pkg::cmd_t cmd;

  // Configuration must only be written while idle (a user rule, unchecked by the block), so always take it.
  assign cfg_ready_o = 1'b1;

  // Controller: sequences capture and commit, owns the result valid.
  dsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: memories, stack pointer, fresh counter, live count, handle adder.
  dsa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .operation_i  (operation_i),
    .index_i      (index_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .handle_o     (handle_o),
    .live_slots_o (live_slots_o)
  );

endmodule

[sv/dsa_ctrl.sv]
// Controller state machine of the descriptor slot allocator.
module dsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dsa_pkg::cmd_t cmd_o
);

  dsa_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      dsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = dsa_pkg::S_EXEC;
        end
      end
      dsa_pkg::S_EXEC: begin
        // hold until the result register has room
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = dsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dsa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/dsa_datapath.sv]
// Datapath: free stack, in-use map, counters, configuration and result register.
module dsa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dsa_pkg::cmd_t                       cmd_i,
  input  logic [1:0]                          operation_i,
  input  logic [dsa_pkg::IDX_W-1:0]           index_i,
  input  logic                                cfg_we_i,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dsa_pkg::ADDR_W-1:0]          cfg_data_i,
  output logic [1:0]                          status_o,
  output logic [dsa_pkg::IDX_W-1:0]           slot_o,
  output logic [dsa_pkg::ADDR_W-1:0]          handle_o,
  output logic [dsa_pkg::CNT_W-1:0]           live_slots_o
);

  localparam int IW = dsa_pkg::IDX_W;
  localparam int CW = dsa_pkg::CNT_W;
  localparam int AW = dsa_pkg::ADDR_W;
  localparam int PW = dsa_pkg::PROD_W;
  localparam int N  = dsa_pkg::SLOT_COUNT;
  localparam logic [CW-1:0] FULL_CNT = CW'(N);

  // configuration
  logic [AW-1:0]             cpu_base_q, gpu_base_q;
  logic [dsa_pkg::SIZE_W-1:0] desc_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_q  <= '0;
      gpu_base_q  <= '0;
      desc_size_q <= dsa_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (dsa_pkg::reg_e'(cfg_index_i))
        dsa_pkg::REG_CPU_BASE:  cpu_base_q  <= cfg_data_i;
        dsa_pkg::REG_GPU_BASE:  gpu_base_q  <= cfg_data_i;
        dsa_pkg::REG_DESC_SIZE: desc_size_q <= cfg_data_i[dsa_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]    op_q;
  logic [IW-1:0] idx_q;
  logic [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      idx_q  <= index_i;
      prod_q <= PW'(index_i) * PW'(desc_size_q);
    end
  end

  // counters
  logic [CW-1:0] free_top_q, free_top_d;
  logic [CW-1:0] next_fresh_q, next_fresh_d;
  logic [CW-1:0] live_q, live_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q   <= '0;
      next_fresh_q <= '0;
      live_q       <= '0;
    end else if (cmd_i.commit) begin
      free_top_q   <= free_top_d;
      next_fresh_q <= next_fresh_d;
      live_q       <= live_d;
    end
  end

  // free stack memory
  logic [IW-1:0] stack_mem [N];
  logic [IW-1:0] stack_rd_q;
  logic          stack_we;
  logic [IW-1:0] stack_wa;
  logic [IW-1:0] stack_ra;
  logic [CW-1:0] top_minus_one;

  assign top_minus_one = free_top_q - CW'(1);
  assign stack_ra      = top_minus_one[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= idx_q;
    end
    if (cmd_i.capture) begin
      stack_rd_q <= stack_mem[stack_ra];
    end
  end

  // in-use map memory; entries at or above next_fresh were never written
  // and read as clear
  logic map_mem [N];
  logic map_rd_q;
  logic map_we;
  logic [IW-1:0] map_wa;
  logic map_wd;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cmd_i.capture) begin
      map_rd_q <= map_mem[index_i];
    end
  end

  // execute
  logic                   in_use;
  dsa_pkg::status_e       status_d;
  logic [IW-1:0]          slot_d;
  logic [AW-1:0]          handle_d;

  assign in_use = (CW'(idx_q) < next_fresh_q) && map_rd_q;

  always_comb begin
    free_top_d   = free_top_q;
    next_fresh_d = next_fresh_q;
    live_d       = live_q;
    status_d     = dsa_pkg::ST_OK;
    slot_d       = '0;
    handle_d     = '0;
    stack_we     = 1'b0;
    stack_wa     = free_top_q[IW-1:0];
    map_we       = 1'b0;
    map_wa       = idx_q;
    map_wd       = 1'b0;
    case (dsa_pkg::op_e'(op_q))
      dsa_pkg::OP_ALLOC: begin
        if (free_top_q != '0) begin
          // pop the most recently released index
          free_top_d = top_minus_one;
          slot_d     = stack_rd_q;
          live_d     = live_q + CW'(1);
          map_we     = cmd_i.commit;
          map_wa     = stack_rd_q;
          map_wd     = 1'b1;
        end else if (next_fresh_q < FULL_CNT) begin
          next_fresh_d = next_fresh_q + CW'(1);
          slot_d       = next_fresh_q[IW-1:0];
          live_d       = live_q + CW'(1);
          map_we       = cmd_i.commit;
          map_wa       = next_fresh_q[IW-1:0];
          map_wd       = 1'b1;
        end else begin
          status_d = dsa_pkg::ST_FULL;
        end
      end
      dsa_pkg::OP_RELEASE: begin
        if (in_use && (free_top_q < FULL_CNT)) begin
          map_we     = cmd_i.commit;
          map_wd     = 1'b0;
          stack_we   = cmd_i.commit;
          free_top_d = free_top_q + CW'(1);
          if (live_q != '0) begin
            live_d = live_q - CW'(1);
          end
        end else begin
          status_d = dsa_pkg::ST_NOT_IN_USE;
        end
      end
      dsa_pkg::OP_CPU_QUERY, dsa_pkg::OP_GPU_QUERY: begin
        if (in_use) begin
          handle_d = ((op_q == dsa_pkg::OP_CPU_QUERY) ? cpu_base_q : gpu_base_q)
                     + AW'(prod_q);
        end else begin
          status_d = dsa_pkg::ST_NOT_IN_USE;
        end
      end
      default: begin
        status_d = dsa_pkg::ST_OK;
      end
    endcase
  end

  // result register
  logic [1:0]    status_q;
  logic [IW-1:0] slot_q;
  logic [AW-1:0] handle_q;
  logic [CW-1:0] live_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= status_d;
      slot_q     <= slot_d;
      handle_q   <= handle_d;
      live_out_q <= live_d;
    end
  end

  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign handle_o     = handle_q;
  assign live_slots_o = live_out_q;

endmodule
